/* design/tfm_pkg.sv */
// tfm_pkg: shared types, constants and helpers for the trigger fire-mode controller
// no dependencies; every other design file imports it
package tfm_pkg;

    localparam int TIME_BITS      = 32;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 16;
    localparam int FIFO_DEPTH     = 2;
    localparam int FIFO_PTR_BITS  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS  = $clog2(FIFO_DEPTH + 1);

    localparam logic [TIME_BITS-1:0] LONG_HOLD_MS     = TIME_BITS'(2000);
    localparam logic [TIME_BITS-1:0] SAFETY_WINDOW_MS = TIME_BITS'(1000);

    typedef logic [TIME_BITS-1:0] t_time;

    typedef enum logic [1:0] {
        MODE_FULL_AUTO = 2'd0,
        MODE_BURST     = 2'd1,
        MODE_AUTO_RESP = 2'd2,
        MODE_SINGLE    = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_FIRING_MODE    = 3'd0,
        CFG_BURST_SIZE     = 3'd1,
        CFG_SAFETY_SHOT    = 3'd2,
        CFG_ROUND_DELAY_MS = 3'd3,
        CFG_DEBOUNCE_MS    = 3'd4,
        CFG_AMMO_LIMIT     = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic       fire;
        logic [7:0] queued_shots;
        logic       pulled;
        logic       clear_shot_total;
    } t_res;

    function automatic logic [7:0] sat_inc(input logic [7:0] v);
        return (v == 8'hff) ? v : v + 8'd1;
    endfunction

endpackage

/* design/tfm_in_if.sv */
// tfm_in_if: input tick channel, valid/ready with the tick fields
// depends on tfm_pkg
interface tfm_in_if import tfm_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [31:0] now_ms;
    logic        pin_a_level;
    logic        pin_b_level;
    logic [15:0] shots_total;

    modport source (output valid, now_ms, pin_a_level, pin_b_level, shots_total,
                    input ready);
    modport sink   (input valid, now_ms, pin_a_level, pin_b_level, shots_total,
                    output ready);
endinterface

/* design/tfm_out_if.sv */
// tfm_out_if: result channel, valid/ready with the per-tick result fields
// depends on tfm_pkg
interface tfm_out_if import tfm_pkg::*; ();
    logic       valid;
    logic       ready;
    logic       fire;
    logic [7:0] queued_shots;
    logic       pulled;
    logic       clear_shot_total;

    modport source (output valid, fire, queued_shots, pulled, clear_shot_total,
                    input ready);
    modport sink   (input valid, fire, queued_shots, pulled, clear_shot_total,
                    output ready);
endinterface

/* design/tfm_front.sv */
// tfm_front: accepts ticks, holds config and trigger/queue state, evaluates one tick per beat
// depends on tfm_pkg and tfm_in_if
module tfm_front import tfm_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    tfm_in_if.sink                   i_in,
    input  logic                     i_space,
    output logic                     o_push,
    output t_res                     o_res
);

    t_mode       r_firing_mode;
    logic [7:0]  r_burst_size;
    logic [7:0]  r_safety_shot;
    logic [15:0] r_round_delay_ms;
    logic [15:0] r_debounce_ms;
    logic [15:0] r_ammo_limit;

    t_time       r_change_time, n_change_time;
    t_time       r_press_time, n_press_time;
    t_time       r_queue_time, n_queue_time;
    t_time       r_last_shot_time, n_last_shot_time;
    logic [7:0]  r_safety_count, n_safety_count;
    logic        r_pulled, n_pulled;
    logic [7:0]  r_shot_queue, n_shot_queue;

    logic        acc;
    t_time       now, e_change, e_repeat, hold, shot_gap;
    logic        held, past_db, safety_ok, long_hold;
    logic        do_pull, do_repeat, do_release, do_fire, clear_total;
    logic [7:0]  limit;

    assign i_in.ready = i_space;
    assign acc        = i_in.valid && i_space;
    assign o_push     = acc;

    always_comb begin
        now         = TIME_BITS'(i_in.now_ms);
        shot_gap    = TIME_BITS'(r_round_delay_ms);
        held        = !i_in.pin_a_level || !i_in.pin_b_level;
        e_change    = now - r_change_time;
        past_db     = e_change >= TIME_BITS'(r_debounce_ms);
        safety_ok   = (r_safety_count >= r_safety_shot) || (r_safety_shot == 8'd0);

        n_pulled         = r_pulled;
        n_change_time    = r_change_time;
        n_press_time     = r_press_time;
        n_queue_time     = r_queue_time;
        n_last_shot_time = r_last_shot_time;
        n_shot_queue     = r_shot_queue;
        n_safety_count   = r_safety_count;
        clear_total      = 1'b0;

        // debounced press
        do_pull = !r_pulled && held && past_db;
        if (do_pull) begin
            n_pulled      = 1'b1;
            n_change_time = now;
            n_press_time  = now;
            case (r_firing_mode)
                MODE_BURST:     n_shot_queue = safety_ok ? r_burst_size : 8'd1;
                MODE_AUTO_RESP: n_shot_queue = sat_inc(r_shot_queue);
                default:        n_shot_queue = 8'd1;
            endcase
        end

        // full auto repeat while held
        e_repeat  = do_pull ? '0 : e_change;
        do_repeat = n_pulled && held && past_db && (e_repeat >= shot_gap) &&
                    (r_firing_mode == MODE_FULL_AUTO);
        if (do_repeat) begin
            n_change_time = now;
            if ((r_safety_count > r_safety_shot) || (r_safety_shot == 8'd0)) begin
                n_shot_queue = 8'd1;
            end
        end

        // debounced release
        hold       = now - r_press_time;
        long_hold  = hold >= LONG_HOLD_MS;
        do_release = r_pulled && !held && past_db;
        if (do_release) begin
            n_pulled      = 1'b0;
            n_change_time = now;
            if ((r_firing_mode == MODE_AUTO_RESP) && !long_hold && safety_ok) begin
                n_shot_queue = sat_inc(n_shot_queue);
            end
            if ((r_ammo_limit != 16'd0) && (i_in.shots_total >= r_ammo_limit) &&
                long_hold) begin
                clear_total = 1'b1;
            end
        end

        // shot release, spaced by the round delay
        limit   = (r_safety_shot == 8'hff) ? 8'hff : r_safety_shot + 8'd1;
        do_fire = (n_shot_queue != 8'd0) && ((now - r_queue_time) >= shot_gap);
        if (do_fire) begin
            n_last_shot_time = now;
            n_safety_count   = sat_inc(r_safety_count);
            if (n_safety_count > limit) begin
                n_safety_count = limit;
            end
            n_shot_queue = n_shot_queue - 8'd1;
            n_queue_time = now;
        end else if ((now - r_last_shot_time) > SAFETY_WINDOW_MS) begin
            n_safety_count = 8'd0;
        end

        o_res.fire             = do_fire;
        o_res.queued_shots     = n_shot_queue;
        o_res.pulled           = n_pulled;
        o_res.clear_shot_total = clear_total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_firing_mode    <= MODE_SINGLE;
            r_burst_size     <= 8'd3;
            r_safety_shot    <= 8'd0;
            r_round_delay_ms <= 16'd50;
            r_debounce_ms    <= 16'd10;
            r_ammo_limit     <= 16'd0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_FIRING_MODE:    r_firing_mode    <= t_mode'(i_cfg_data[1:0]);
                CFG_BURST_SIZE:     r_burst_size     <= i_cfg_data[7:0];
                CFG_SAFETY_SHOT:    r_safety_shot    <= i_cfg_data[7:0];
                CFG_ROUND_DELAY_MS: r_round_delay_ms <= i_cfg_data;
                CFG_DEBOUNCE_MS:    r_debounce_ms    <= i_cfg_data;
                CFG_AMMO_LIMIT:     r_ammo_limit     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_change_time    <= '0;
            r_press_time     <= '0;
            r_queue_time     <= '0;
            r_last_shot_time <= '0;
            r_safety_count   <= 8'd0;
            r_pulled         <= 1'b0;
            r_shot_queue     <= 8'd0;
        end else if (acc) begin
            r_change_time    <= n_change_time;
            r_press_time     <= n_press_time;
            r_queue_time     <= n_queue_time;
            r_last_shot_time <= n_last_shot_time;
            r_safety_count   <= n_safety_count;
            r_pulled         <= n_pulled;
            r_shot_queue     <= n_shot_queue;
        end
    end

    a_fire_marks_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && do_fire) |=> (r_queue_time == r_last_shot_time) && (r_safety_count != 8'd0))
        else $error("shot beat did not record its time or safety count");

    a_idle_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !acc |=> $stable(r_shot_queue) && $stable(r_pulled) && $stable(r_change_time))
        else $error("tick state moved without an accepted beat");

endmodule

/* design/tfm_fifo.sv */
// tfm_fifo: short result queue between the tick evaluator and the output stage
// depends on tfm_pkg
module tfm_fifo import tfm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_res i_data,
    output logic o_space,
    input  logic i_pop,
    output logic o_valid,
    output t_res o_data
);

    t_res                     r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] r_wr_ptr, r_rd_ptr;
    logic [FIFO_CNT_BITS-1:0] r_count;
    logic                     push_ok, pop_ok;

    assign o_space = r_count != FIFO_CNT_BITS'(FIFO_DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];
    assign push_ok = i_push && o_space;
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= (r_wr_ptr == FIFO_PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= (r_rd_ptr == FIFO_PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + FIFO_CNT_BITS'(push_ok) - FIFO_CNT_BITS'(pop_ok);
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_CNT_BITS'(FIFO_DEPTH))
        else $error("result queue count above depth");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_ok && !pop_ok) |=> r_count == $past(r_count) + 1'b1)
        else $error("result queue count missed a push");

endmodule

/* design/tfm_back.sv */
// tfm_back: output register stage, drains the result queue onto the result channel
// depends on tfm_pkg and tfm_out_if
module tfm_back import tfm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_res       i_data,
    output logic       o_pop,
    tfm_out_if.source  o_out
);

    logic r_valid;
    t_res r_data;

    assign o_pop = i_valid && (!r_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || o_out.ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= i_data;
        end
    end

    assign o_out.valid            = r_valid;
    assign o_out.fire             = r_data.fire;
    assign o_out.queued_shots     = r_data.queued_shots;
    assign o_out.pulled           = r_data.pulled;
    assign o_out.clear_shot_total = r_data.clear_shot_total;

endmodule

/* design/trigger_fire_mode_controller.sv */
// trigger_fire_mode_controller: top level, tick evaluator, result queue and output stage
// depends on tfm_pkg, tfm_in_if, tfm_out_if, tfm_front, tfm_fifo, tfm_back

// One result beat comes out for every tick beat taken in, in order. A tick is evaluated in
// the cycle it is accepted (debounce, mode queueing, shot spacing, safety counter all in one
// pass of the front stage), so a new tick can be taken every clock while the queue has space;
// the result then passes a two-entry queue and an output register. Ticks keep being accepted
// while the sink stalls until the queue fills. The user must keep registers written through
// the write port only while no tick is in flight; the block itself does not enforce it.
module trigger_fire_mode_controller import tfm_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    tfm_in_if.sink                   i_in,
    tfm_out_if.source                o_out
);

    logic push, space, pop, q_valid;
    t_res front_res, q_data;

    tfm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_space    (space),
        .o_push     (push),
        .o_res      (front_res)
    );

    tfm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_res),
        .o_space (space),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    tfm_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_data  (q_data),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

/* sim/trigger_fire_mode_controller_test.sv */
// trigger_fire_mode_controller_test: self-checking bench for the trigger fire-mode controller
// depends on tfm_pkg, tfm_in_if, tfm_out_if and trigger_fire_mode_controller
// directed mode cases, then queue saturation and randomized trigger phases, checked per beat
`timescale 1ns / 100ps

module trigger_fire_mode_controller_test;
    import tfm_pkg::*;

    localparam int CYCLE_LIMIT = 500000;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_idx;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    tfm_in_if  tick_if ();
    tfm_out_if res_if ();

    trigger_fire_mode_controller dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (tick_if),
        .o_out      (res_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // controller settings as last written
    t_mode       set_mode     = MODE_SINGLE;
    logic [7:0]  set_burst    = 8'd3;
    logic [7:0]  set_safety   = 8'd0;
    logic [15:0] set_round    = 16'd50;
    logic [15:0] set_debounce = 16'd10;
    logic [15:0] set_ammo     = 16'd0;

    // trigger and shot timing state
    t_time      change_t      = '0;
    t_time      press_t       = '0;
    t_time      queue_t       = '0;
    t_time      last_shot_t   = '0;
    logic [7:0] safety_cnt    = 8'd0;
    logic       pulled_st     = 1'b0;
    logic [7:0] shots_waiting = 8'd0;

    t_res tick_results_q [$];
    t_res oldest_result;
    int   mismatches = 0;
    int   cycle_count = 0;
    int   src_gap_max = 18;
    int   sink_stall_max = 18;
    t_time tick_now = '0;

    function automatic t_res predict_tick(input t_time now, input logic pin_a,
                                          input logic pin_b, input logic [15:0] shots);
        t_res       r;
        logic       held;
        logic       settled;
        logic       safe_ok;
        t_time      hold_ms;
        logic [7:0] cap;
        r = '0;
        held = !pin_a || !pin_b;
        settled = (now - change_t) >= t_time'(set_debounce);
        safe_ok = (safety_cnt >= set_safety) || (set_safety == 8'd0);

        if (!pulled_st && held && settled) begin
            pulled_st = 1'b1;
            change_t = now;
            press_t = now;
            case (set_mode)
                MODE_BURST: shots_waiting = safe_ok ? set_burst : 8'd1;
                MODE_AUTO_RESP: shots_waiting = (shots_waiting == 8'hff) ? shots_waiting
                                                                       : shots_waiting + 8'd1;
                default: shots_waiting = 8'd1;
            endcase
        end

        if (pulled_st && held && settled && (now - change_t) >= t_time'(set_round) &&
            set_mode == MODE_FULL_AUTO) begin
            change_t = now;
            if (safety_cnt > set_safety || set_safety == 8'd0)
                shots_waiting = 8'd1;
        end

        if (pulled_st && !held && settled) begin
            hold_ms = now - press_t;
            pulled_st = 1'b0;
            change_t = now;
            if (set_mode == MODE_AUTO_RESP && hold_ms < LONG_HOLD_MS && safe_ok)
                shots_waiting = (shots_waiting == 8'hff) ? shots_waiting : shots_waiting + 8'd1;
            if (set_ammo != 16'd0 && shots >= set_ammo && hold_ms >= LONG_HOLD_MS)
                r.clear_shot_total = 1'b1;
        end

        if (shots_waiting != 8'd0 && (now - queue_t) >= t_time'(set_round)) begin
            cap = (set_safety == 8'hff) ? 8'hff : set_safety + 8'd1;
            last_shot_t = now;
            if (safety_cnt != 8'hff)
                safety_cnt = safety_cnt + 8'd1;
            if (safety_cnt > cap)
                safety_cnt = cap;
            shots_waiting = shots_waiting - 8'd1;
            queue_t = now;
            r.fire = 1'b1;
        end

        if ((now - last_shot_t) > SAFETY_WINDOW_MS)
            safety_cnt = 8'd0;

        r.queued_shots = shots_waiting;
        r.pulled = pulled_st;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on %s: got %0h, expected %0h", what, got, want);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && tick_if.valid === 1'b1 && tick_if.ready === 1'b1)
            tick_results_q.push_back(predict_tick(tick_if.now_ms, tick_if.pin_a_level,
                                                  tick_if.pin_b_level, tick_if.shots_total));
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            if (tick_results_q.size() == 0) begin
                report_mismatch("unexpected result beat", res_if.queued_shots, '0);
            end else begin
                oldest_result = tick_results_q.pop_front();
                if (res_if.fire !== oldest_result.fire)
                    report_mismatch("fire", res_if.fire, oldest_result.fire);
                if (res_if.queued_shots !== oldest_result.queued_shots)
                    report_mismatch("queued_shots", res_if.queued_shots,
                                    oldest_result.queued_shots);
                if (res_if.pulled !== oldest_result.pulled)
                    report_mismatch("pulled", res_if.pulled, oldest_result.pulled);
                if (res_if.clear_shot_total !== oldest_result.clear_shot_total)
                    report_mismatch("clear_shot_total", res_if.clear_shot_total,
                                    oldest_result.clear_shot_total);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // result sink with random stalls
    initial begin
        int unsigned stall;
        res_if.ready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            stall = $urandom_range(0, sink_stall_max);
            if (stall != 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (res_if.valid !== 1'b1);
        end
    end

    task automatic send_tick(input int unsigned dt, input logic pin_a, input logic pin_b,
                             input logic [15:0] shots);
        int unsigned gap;
        gap = $urandom_range(0, src_gap_max);
        tick_now = tick_now + t_time'(dt);
        if (gap != 0) begin
            tick_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        tick_if.valid       <= 1'b1;
        tick_if.now_ms      <= tick_now;
        tick_if.pin_a_level <= pin_a;
        tick_if.pin_b_level <= pin_b;
        tick_if.shots_total <= shots;
        do @(posedge i_clk); while (tick_if.ready !== 1'b1);
    endtask

    task automatic wait_results_drained();
        tick_if.valid <= 1'b0;
        @(posedge i_clk);
        while (tick_results_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic load_config(input t_mode mode, input logic [7:0] burst,
                               input logic [7:0] safety, input logic [15:0] round_ms,
                               input logic [15:0] debounce, input logic [15:0] ammo);
        t_cfg_idx    regs [6];
        logic [15:0] vals [6];
        regs = '{CFG_FIRING_MODE, CFG_BURST_SIZE, CFG_SAFETY_SHOT,
                 CFG_ROUND_DELAY_MS, CFG_DEBOUNCE_MS, CFG_AMMO_LIMIT};
        // unused upper data bits carry junk on the narrow registers
        vals = '{{14'($urandom), mode}, {8'($urandom), burst}, {8'($urandom), safety},
                 round_ms, debounce, ammo};
        for (int i = 0; i < 6; i++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= regs[i];
            cfg_data <= vals[i];
            @(posedge i_clk);
        end
        cfg_we <= 1'b0;
        set_mode     = mode;
        set_burst    = burst;
        set_safety   = safety;
        set_round    = round_ms;
        set_debounce = debounce;
        set_ammo     = ammo;
    endtask

    task automatic test_single_shot_defaults();
        send_tick(0, 1'b1, 1'b1, 16'h0000);
        send_tick(5, 1'b0, 1'b1, 16'hffff);
        send_tick(7, 1'b0, 1'b1, 16'h0000);
        send_tick(38, 1'b0, 1'b0, 16'h5a5a);
        send_tick(5, 1'b1, 1'b1, 16'ha5a5);
        send_tick(1, 1'b1, 1'b0, 16'h0000);
        send_tick(14, 1'b1, 1'b0, 16'h0000);
        tick_now = 32'hffff_fff0;
        send_tick(0, 1'b0, 1'b0, 16'hffff);
        // release lands on all-ones time, next pull wraps through zero
        send_tick(15, 1'b1, 1'b1, 16'hffff);
        send_tick(17, 1'b0, 1'b0, 16'h0000);
        send_tick(1500, 1'b1, 1'b1, 16'h0000);
    endtask

    task automatic test_mode_specials();
        wait_results_drained();
        // empty burst
        load_config(MODE_BURST, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0);
        send_tick(3, 1'b0, 1'b0, 16'd0);
        send_tick(3, 1'b1, 1'b1, 16'd0);
        wait_results_drained();
        load_config(MODE_FULL_AUTO, 8'd255, 8'd2, 16'd10, 16'd0, 16'd0);
        repeat (5) send_tick(10, 1'b0, 1'b1, 16'd0);
        send_tick(10, 1'b1, 1'b1, 16'd0);
        wait_results_drained();
        // safety limit at the top, short pull, then a long hold clearing the total
        load_config(MODE_AUTO_RESP, 8'd3, 8'hff, 16'd0, 16'd2, 16'd100);
        send_tick(5, 1'b0, 1'b0, 16'd100);
        send_tick(5, 1'b1, 1'b1, 16'd100);
        send_tick(5, 1'b1, 1'b0, 16'd100);
        send_tick(2500, 1'b1, 1'b0, 16'd100);
        send_tick(5, 1'b1, 1'b1, 16'd100);
    endtask

    task automatic test_auto_resp_saturation();
        wait_results_drained();
        load_config(MODE_AUTO_RESP, 8'd1, 8'd0, 16'hffff, 16'd0, 16'd0);
        repeat (140) begin
            send_tick(1, 1'b0, 1'b0, 16'($urandom));
            send_tick(1, 1'b1, 1'b1, 16'($urandom));
        end
    endtask

    task automatic random_ticks(input int count);
        int          seg_left;
        int          step_max;
        logic        held_seg;
        logic        pa;
        logic        pb;
        logic [15:0] shots;
        int unsigned dt;
        seg_left = 0;
        step_max = 5;
        held_seg = 1'b0;
        for (int n = 0; n < count; n++) begin
            if (seg_left == 0) begin
                held_seg = !held_seg;
                seg_left = $urandom_range(1, 30);
                case ($urandom_range(0, 3))
                    0: step_max = 2;
                    1, 2: step_max = 25;
                    default: step_max = 400;
                endcase
            end
            seg_left--;
            pa = 1'b1;
            pb = 1'b1;
            if ($urandom_range(0, 9) == 0) begin
                pa = 1'($urandom);
                pb = 1'($urandom);
            end else if (held_seg) begin
                case ($urandom_range(0, 2))
                    0: begin
                        pa = 1'b0;
                        pb = 1'b0;
                    end
                    1: pa = 1'b0;
                    default: pb = 1'b0;
                endcase
            end
            shots = ($urandom_range(0, 2) == 0) ? 16'($urandom)
                                                : set_ammo + 16'($urandom_range(0, 2)) - 16'd1;
            dt = $urandom_range(0, step_max);
            if ($urandom_range(0, 199) == 0)
                tick_now = $urandom;
            send_tick(dt, pa, pb, shots);
            if ($urandom_range(0, 149) == 0)
                wait_results_drained();
        end
    endtask

    task automatic test_random_phases();
        t_mode mode;
        for (int p = 0; p < 9; p++) begin
            wait_results_drained();
            mode = t_mode'(p % 4);
            if (p == 2) begin
                src_gap_max = 0;
                sink_stall_max = 0;
            end else begin
                src_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 18;
                sink_stall_max = ($urandom_range(0, 2) == 0) ? 0 : 18;
            end
            if (p == 0)
                load_config(mode, 8'd1, 8'd0, 16'd0, 16'd0, 16'd1);
            else if (p == 1)
                load_config(mode, 8'd255, 8'd254, 16'hffff, 16'hffff, 16'hffff);
            else
                load_config(mode, 8'($urandom_range(1, 8)), 8'($urandom_range(0, 6)),
                            16'($urandom_range(0, 80)), 16'($urandom_range(0, 25)),
                            ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom_range(1, 60)));
            random_ticks(95);
        end
    endtask

    initial begin
        i_rst_n             <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_idx             <= CFG_FIRING_MODE;
        cfg_data            <= '0;
        tick_if.valid       <= 1'b0;
        tick_if.now_ms      <= '0;
        tick_if.pin_a_level <= 1'b1;
        tick_if.pin_b_level <= 1'b1;
        tick_if.shots_total <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_shot_defaults();
        test_mode_specials();
        test_auto_resp_saturation();
        test_random_phases();
        wait_results_drained();

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
